/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* hdl/mau_pkg.sv */
// Package of the modular arithmetic unit: widths, codes and item types
package mau_pkg;
  localparam int unsigned DataWidth = 32;
  localparam logic [DataWidth-1:0] ModulusReset = DataWidth'(2);

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_INV = 2'd3
  } op_e;

  typedef struct packed {
    logic [1:0]           operation;
    logic [DataWidth-1:0] operand_a;
    logic [DataWidth-1:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [DataWidth-1:0] result;
    logic                 no_inverse;
  } out_item_t;
endpackage

/* hdl/modular_arithmetic_unit_core.sv */
// Operands are reduced by a bit-serial restoring divider; multiply is bit-serial
// double-and-add; an inverse runs at most about 1.44W Euclid steps, each of them one
// division, one multiply and one coefficient update. One item at a time; the next
// item is accepted after the result.
// Reset (rst_ni low, asynchronous): modulus = 2, controller idle, no result pending.
`include "assert_macros.svh"
module modular_arithmetic_unit_core import mau_pkg::*; #(
  parameter int unsigned Width = DataWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic [DataWidth-1:0] cfg_wdata_i,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);
  localparam int unsigned CntW = $clog2(Width + 2);

  typedef enum logic [3:0] {
    ST_IDLE, ST_RED_A, ST_RED_B, ST_EXEC, ST_MUL, ST_INV_DIV, ST_INV_MUL, ST_INV_UPD,
    ST_OUT
  } state_e;

  state_e state_q;
  logic [Width-1:0] mod_q;
  logic [1:0]       op_q;
  logic [Width-1:0] a_q, b_q;
  // divider: remainder, quotient/dividend shift register
  logic [Width:0]   rem_q;
  logic [Width-1:0] quo_q;
  logic [CntW-1:0]  cnt_q;
  // Euclid state
  logic [Width-1:0] r0_q, r1_q, t0_q, t1_q;
  // multiplier accumulator and multiplier shift register
  logic [Width-1:0] acc_q, mr_q;
  logic [Width-1:0] res_q;
  logic             none_q, out_valid_q;

  // serial helpers
  logic [Width:0]   rem_sh, rem_sub;
  logic [Width:0]   dbl, dbl_r, add_s, add_r;
  logic [Width-1:0] mcand, divisor;
  logic [Width:0]   sum_ab;

  assign rem_sh  = {rem_q[Width-1:0], quo_q[Width-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign dbl     = {acc_q, 1'b0};
  assign dbl_r   = (dbl >= {1'b0, mod_q}) ? dbl - {1'b0, mod_q} : dbl;
  assign add_s   = dbl_r + {1'b0, mcand};
  assign add_r   = (add_s >= {1'b0, mod_q}) ? add_s - {1'b0, mod_q} : add_s;
  assign sum_ab  = {1'b0, a_q} + {1'b0, b_q};

  always_comb begin
    divisor = (state_q == ST_INV_DIV) ? r1_q : mod_q;
    mcand   = (state_q == ST_INV_MUL) ? t1_q : a_q;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = '{result: DataWidth'(res_q), no_inverse: none_q};

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q <= Width'(ModulusReset);
    end else if (cfg_we_i) begin
      mod_q <= cfg_wdata_i[Width-1:0];
    end
  end

  // controller and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            op_q    <= in_item_i.operation;
            a_q     <= in_item_i.operand_a[Width-1:0];
            b_q     <= in_item_i.operand_b[Width-1:0];
            quo_q   <= in_item_i.operand_a[Width-1:0];
            rem_q   <= '0;
            cnt_q   <= '0;
            state_q <= ST_RED_A;
          end
        end
        ST_RED_A, ST_RED_B, ST_INV_DIV: begin
          if (cnt_q == CntW'(Width - 1)) begin
            // last divide step: hand the remainder on
            cnt_q <= '0;
            if (state_q == ST_RED_A) begin
              a_q     <= (rem_sh >= {1'b0, divisor}) ? rem_sub[Width-1:0]
                                                     : rem_sh[Width-1:0];
              quo_q   <= b_q;
              rem_q   <= '0;
              state_q <= ST_RED_B;
            end else if (state_q == ST_RED_B) begin
              b_q     <= (rem_sh >= {1'b0, divisor}) ? rem_sub[Width-1:0]
                                                     : rem_sh[Width-1:0];
              state_q <= ST_EXEC;
            end else begin
              // quotient is final; remainder becomes new r1
              r0_q    <= r1_q;
              r1_q    <= (rem_sh >= {1'b0, divisor}) ? rem_sub[Width-1:0]
                                                     : rem_sh[Width-1:0];
              mr_q    <= {quo_q[Width-2:0], (rem_sh >= {1'b0, divisor})};
              acc_q   <= '0;
              state_q <= ST_INV_MUL;
            end
          end else begin
            // one restoring divide step
            if (rem_sh >= {1'b0, divisor}) begin
              rem_q <= rem_sub;
              quo_q <= {quo_q[Width-2:0], 1'b1};
            end else begin
              rem_q <= rem_sh;
              quo_q <= {quo_q[Width-2:0], 1'b0};
            end
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_EXEC: begin
          none_q <= 1'b0;
          if (mod_q >= Width'(2)) begin
            case (op_q)
              OP_ADD: begin
                res_q   <= (sum_ab >= {1'b0, mod_q}) ? Width'(sum_ab - {1'b0, mod_q})
                                                     : sum_ab[Width-1:0];
                state_q <= ST_OUT;
              end
              OP_SUB: begin
                res_q   <= (a_q >= b_q) ? a_q - b_q : a_q - b_q + mod_q;
                state_q <= ST_OUT;
              end
              OP_MUL: begin
                acc_q   <= '0;
                mr_q    <= b_q;
                cnt_q   <= '0;
                state_q <= ST_MUL;
              end
              default: begin
                r0_q <= mod_q;
                r1_q <= a_q;
                t0_q <= '0;
                t1_q <= Width'(1);
                state_q <= ST_INV_UPD;
              end
            endcase
          end else begin
            res_q   <= '0;
            state_q <= ST_OUT;
          end
        end
        ST_MUL, ST_INV_MUL: begin
          // double and add, multiplier msb first (quotient used unreduced, at most the modulus)
          if (cnt_q == CntW'(Width - 1)) begin
            cnt_q <= '0;
            if (state_q == ST_MUL) begin
              res_q   <= mr_q[Width-1] ? add_r[Width-1:0] : dbl_r[Width-1:0];
              state_q <= ST_OUT;
            end else begin
              // q*t1 mod m; the update then forms t2 = t0 - q*t1 mod m
              acc_q   <= mr_q[Width-1] ? add_r[Width-1:0] : dbl_r[Width-1:0];
              state_q <= ST_INV_UPD;
            end
          end else begin
            acc_q <= mr_q[Width-1] ? add_r[Width-1:0] : dbl_r[Width-1:0];
            mr_q  <= {mr_q[Width-2:0], 1'b0};
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_INV_UPD: begin
          if (cnt_q == '0 && r0_q != mod_q || cnt_q != '0) begin
            // finish the coefficient update after a step
            t0_q <= t1_q;
            t1_q <= (t0_q >= acc_q) ? t0_q - acc_q : t0_q - acc_q + mod_q;
          end
          cnt_q <= '0;
          // mark first entry by r0 == modulus with t1 == 1, t0 == 0
          if (r1_q == '0 || (r0_q != mod_q && r1_q == '0)) begin
            // the coefficient of the final remainder is the one shifted into t0
            none_q  <= (r0_q != Width'(1));
            res_q   <= (r0_q != Width'(1)) ? '0 : t1_q;
            state_q <= ST_OUT;
          end else begin
            quo_q   <= r0_q;
            rem_q   <= '0;
            state_q <= ST_INV_DIV;
          end
        end
        ST_OUT: begin
          if (!out_valid_q) begin
            out_valid_q <= 1'b1;
          end else if (out_ready_i) begin
            out_valid_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  `ASSERT_IMPL(a_out_idle, clk_i, rst_ni, out_valid_q, state_q == ST_OUT)
  `ASSERT_IMPL(a_res_range, clk_i, rst_ni, out_valid_q && mod_q >= Width'(2), res_q < mod_q)
  `ASSERT_NEXT(a_accept, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_RED_A)
endmodule

/* dv/tb_modular_arithmetic_unit_core.sv */
// Testbench of the modular arithmetic unit: directed and random items checked against a predictor
module tb_modular_arithmetic_unit_core;
  import mau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 60000;
  localparam int unsigned DrainCycles = 200;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [DataWidth-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_item_t out_item_o;

  // Modulus as the block holds it, and results still owed
  longint unsigned modulus_q = 2;
  out_item_t owed_results[$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned hold_request = 0;
  bit rx_quiet = 1'b0;
  bit tx_quiet = 1'b0;

  modular_arithmetic_unit_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Compute the reduced result of one item under the current modulus
  function automatic out_item_t modular_result(op_e op, logic [31:0] opa, logic [31:0] opb);
    out_item_t res;
    longint unsigned m, a, b;
    longint r0, r1, t0, t1, q, tmp;
    res = '0;
    m = modulus_q;
    if (m < 2) return res;
    a = longint'(opa) % m;
    b = longint'(opb) % m;
    case (op)
      OP_ADD: res.result = DataWidth'((a + b) % m);
      OP_SUB: res.result = DataWidth'((a + m - b) % m);
      OP_MUL: res.result = DataWidth'((a * b) % m);
      default: begin
        r0 = longint'(m);
        r1 = longint'(a);
        t0 = 0;
        t1 = 1;
        while (r1 != 0) begin
          q = r0 / r1;
          tmp = r0 - q * r1;
          r0 = r1;
          r1 = tmp;
          tmp = t0 - q * t1;
          t0 = t1;
          t1 = tmp;
        end
        if (r0 != 1) begin
          res.no_inverse = 1'b1;
        end else begin
          res.result = DataWidth'(((t0 % longint'(m)) + longint'(m)) % longint'(m));
        end
      end
    endcase
    return res;
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(op_e op, logic [31:0] a, logic [31:0] b);
    int unsigned gap, r;
    r = $urandom_range(0, 99);
    gap = (tx_quiet || r < 55) ? 0 : (r < 95) ? $urandom_range(1, 4) : $urandom_range(10, 60);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i.operation <= op;
    in_item_i.operand_a <= a;
    in_item_i.operand_b <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    owed_results.push_back(modular_result(op, a, b));
  endtask

  // Drain the block, then write the modulus
  task automatic write_modulus(logic [31:0] value);
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    modulus_q = value;
  endtask

  // Operand biased toward the edges of the current modulus
  function automatic logic [31:0] pick_operand();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom();
    case (r % 6)
      0: return '0;
      1: return 32'(modulus_q - 1);
      2: return 32'(modulus_q);
      3: return '1;
      4: return 32'(1);
      default: return 32'($urandom_range(0, 15));
    endcase
  endfunction

  task automatic test_reset_modulus();
    send_item(OP_ADD, 32'd1, 32'd1);
    send_item(OP_MUL, '1, '1);
    send_item(OP_INV, 32'd3, 32'd0);
    send_item(OP_INV, 32'd4, 32'd0);
  endtask

  task automatic test_field_extremes();
    write_modulus('1);
    send_item(OP_ADD, '1, 32'hFFFF_FFFE);
    send_item(OP_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
    send_item(OP_SUB, '0, 32'd1);
    send_item(OP_SUB, 32'hFFFF_FFFE, '0);
    send_item(OP_MUL, 32'hFFFF_FFFE, 32'hFFFF_FFFE);
    send_item(OP_MUL, 32'hAAAA_AAAA, 32'h5555_5555);
  endtask

  task automatic test_inverse_cases();
    send_item(OP_INV, 32'd1, '1);
    send_item(OP_INV, '0, '0);
    send_item(OP_INV, '1, '0);
    send_item(OP_INV, 32'd3, '0);
    send_item(OP_INV, 32'd2, '0);
    write_modulus(32'd12);
    send_item(OP_INV, 32'd6, '0);
    send_item(OP_INV, 32'd5, '0);
    send_item(OP_INV, 32'd24, '0);
    send_item(OP_INV, 32'd13, '0);
  endtask

  task automatic test_small_modulus();
    write_modulus(32'd1);
    send_item(OP_ADD, 32'd5, 32'd7);
    send_item(OP_INV, 32'd1, '0);
    write_modulus(32'd0);
    send_item(OP_SUB, '0, 32'd3);
    send_item(OP_MUL, '1, '1);
    send_item(OP_INV, 32'd7, '0);
  endtask

  task automatic test_random_items();
    logic [31:0] moduli[8];
    int unsigned r;
    moduli = '{32'd2, 32'd7, 32'hFFFF_FFFB, '1, 32'h8000_0000, 32'd0, 32'd0, 32'd0};
    for (int k = 0; k < 8; k++) begin
      if (k == 5) moduli[k] = $urandom_range(3, 1000);
      if (k >= 6) moduli[k] = $urandom() | 32'd2;
      write_modulus(moduli[k]);
      tx_quiet = (k == 3);
      rx_quiet = (k == 3);
      for (int n = 0; n < 78; n++) begin
        r = $urandom_range(0, 99);
        send_item(r < 25 ? OP_ADD : r < 50 ? OP_SUB : r < 75 ? OP_MUL : OP_INV,
                  pick_operand(), pick_operand());
      end
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  task automatic test_output_backpressure();
    write_modulus(32'd101);
    hold_request = 600;
    for (int n = 0; n < 6; n++) send_item(OP_MUL, $urandom(), $urandom());
  endtask

  // Receiver: random stalls, a few long ones, and a long hold on request
  always @(posedge clk_i) begin
    int unsigned stall_left;
    int unsigned r;
    if (hold_request > 0) begin
      stall_left = hold_request;
      hold_request = 0;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      r = $urandom_range(0, 99);
      if (!rx_quiet && r < 12) stall_left = $urandom_range(1, 3);
      else if (!rx_quiet && r == 12) stall_left = $urandom_range(20, 90);
    end
  end

  // Check each result against the oldest owed one
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (owed_results.size() == 0) begin
        $error("unexpected result item: result %0h no_inverse %0b",
               out_item_o.result, out_item_o.no_inverse);
        mismatches++;
      end else begin
        want = owed_results.pop_front();
        if (out_item_o.result !== want.result) begin
          $error("result: expected %0h actual %0h", want.result, out_item_o.result);
          mismatches++;
        end
        if (out_item_o.no_inverse !== want.no_inverse) begin
          $error("no_inverse: expected %0b actual %0b", want.no_inverse,
                 out_item_o.no_inverse);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_modulus();
    test_field_extremes();
    test_inverse_cases();
    test_small_modulus();
    test_random_items();
    test_output_backpressure();
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
